[rtl/core/bblur_pkg.sv]
// shared types and constants for the 3x3 clamped box blur
`default_nettype none
package bblur_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_PIXEL_BITS = 16;
   localparam int CSR_BITS       = 13;
   localparam int ROW_BITS       = 12;
   localparam int POS_BITS       = 12;
   localparam int ROW_LIMIT      = 4096;

   localparam logic [CSR_BITS-1:0] RESET_FRAME_WIDTH  = 13'd640;
   localparam logic [CSR_BITS-1:0] RESET_FRAME_HEIGHT = 13'd480;

   // register indexes of the csr port
   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // position and framing of one result
   typedef struct packed {
      logic [POS_BITS-1:0] col;
      logic [POS_BITS-1:0] row;
      logic                last;
   } pos_type;

endpackage
`default_nettype wire

[rtl/core/bblur_cell.sv]
// one window cell: holds a three-row pixel column and passes it on
`default_nettype none
module bblur_cell #(
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift_en,
   input  wire logic [2:0][PIXEL_BITS-1:0] col_in,
   output logic      [2:0][PIXEL_BITS-1:0] col_out
);

   logic [2:0][PIXEL_BITS-1:0] col_ff;
   logic [2:0][PIXEL_BITS-1:0] col_next_in;

   // take the neighbour's column on every shift
   always_comb begin
      col_next_in = shift_en ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_next_in;
      end
   end

   assign col_out = col_ff;

endmodule
`default_nettype wire

[rtl/core/bblur_mean.sv]
// divide-by-nine rounding stage and result output register
`default_nettype none
module bblur_mean
   import bblur_pkg::*;
#(
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [PIXEL_BITS+3:0] in_sum,
   input  wire pos_type               in_pos,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [PIXEL_BITS-1:0]      out_blurred,
   output pos_type                    out_pos
);

   localparam int SUM_BITS = PIXEL_BITS + 4;
   localparam int SHIFT    = SUM_BITS + 4;
   localparam int RCP_BITS = SHIFT - 2;
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) / 9) + 1;
   localparam int PROD_BITS = SUM_BITS + RCP_BITS;

   logic                  sum_valid_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   pos_type               sum_pos_ff;
   logic                  out_valid_ff;
   logic [PIXEL_BITS-1:0] out_blurred_ff;
   pos_type               out_pos_ff;

   logic                  move;
   logic [SUM_BITS-1:0]   rounded;
   logic [PROD_BITS-1:0]  product;
   logic [PIXEL_BITS-1:0] quotient;

   // the sum register drains into the output register when that is free
   assign move     = sum_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !sum_valid_ff || move;

   // (sum + 4) / 9 by reciprocal multiply
   always_comb begin
      rounded  = sum_ff + SUM_BITS'(4);
      product  = PROD_BITS'(rounded) * PROD_BITS'(RCP_BITS'(RECIP));
      quotient = PIXEL_BITS'(product >> SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_valid && in_ready) begin
            sum_valid_ff <= 1'b1;
         end else if (move) begin
            sum_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sum_ff     <= in_sum;
         sum_pos_ff <= in_pos;
      end
      if (move) begin
         out_blurred_ff <= quotient;
         out_pos_ff     <= sum_pos_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_blurred = out_blurred_ff;
   assign out_pos     = out_pos_ff;

endmodule
`default_nettype wire

[rtl/core/box_blur_3x3_clamped.sv]
// top level of the 3x3 clamped box blur over a raster pixel stream
//
//  channel | dir | handshake           | contents
//  req     | in  | req_tvalid/tready   | tdata: pixel; tuser: frame_start
//  rsp     | out | rsp_tvalid/tready   | tdata: blurred, out_col, out_row; tlast: last
//  csr     | in  | csr_we              | csr_addr: register index; csr_wdata: value
//
//  one pixel per clock in the interior of the frame while rsp does not stall; a pixel
//  at the last column or last row holds the input until it has released all its
//  results (up to nine), since the single window adder forms one sum per cycle.
//  a request passes the line store read, the window stage, the sum register,
//  the divide by nine and the output register, in that order.
//  reset clears counters, window cells and valid bits; line stores hold
//  whatever was last written. rsp stalls back up through the sum stage into
//  the window stage and then the request side.
`default_nettype none
module box_blur_3x3_clamped
   import bblur_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS,
   localparam int REQ_BITS  = ((PIXEL_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((PIXEL_BITS + 2 * POS_BITS + 7) / 8) * 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [REQ_BITS-1:0] req_tdata,   // pixel
   input  wire logic                req_tuser,   // frame_start
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RSP_BITS-1:0]      rsp_tdata,   // blurred, out_col, out_row
   output logic                     rsp_tlast,
   input  wire logic                csr_we,
   input  wire logic                csr_addr,
   input  wire logic [CSR_BITS-1:0] csr_wdata
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int PB       = PIXEL_BITS;
   localparam int SUM_BITS = PIXEL_BITS + 4;

   // configuration
   logic [CSR_BITS-1:0] frame_width_ff;
   logic [CSR_BITS-1:0] frame_height_ff;
   logic [COL_BITS-1:0] col_max;
   logic [ROW_BITS-1:0] row_max;
   logic [14:0]         w_ext;

   // input counters
   logic [COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0] row_ff;
   logic [COL_BITS-1:0] col_pre;
   logic [ROW_BITS-1:0] row_pre;
   logic [COL_BITS-1:0] acc_c;
   logic [ROW_BITS-1:0] acc_r;
   logic                acc_lastc;
   logic                acc_lastr;
   logic                req_acc;

   // line store
   logic [2*PB-1:0]     line_mem [MAX_WIDTH];
   logic [2*PB-1:0]     mem_q_ff;

   // read stage
   logic                a_valid_ff;
   logic                a_fresh_ff;
   logic                a_byp_ff;
   logic [2*PB-1:0]     a_hold_ff;
   logic [PB-1:0]       a_px_ff;
   logic [COL_BITS-1:0] a_c_ff;
   logic [ROW_BITS-1:0] a_r_ff;
   logic [1:0]          a_dxs_ff, a_dxe_ff, a_dys_ff, a_dye_ff;
   logic                a_has_ff;
   logic [2*PB-1:0]     a_eff;
   logic [2*PB-1:0]     a_fwd;
   logic [1:0]          acc_dxs, acc_dxe, acc_dys, acc_dye;
   logic                acc_hasx, acc_hasy;

   // window stage
   logic                b_valid_ff;
   logic [PB-1:0]       b_px_ff, b_m1_ff, b_m2_ff;
   logic [COL_BITS-1:0] b_c_ff;
   logic [ROW_BITS-1:0] b_r_ff;
   logic [1:0]          b_dx_ff, b_dy_ff, b_dxs_ff, b_dxe_ff, b_dye_ff;
   logic                b_has_ff;
   logic                b_emit;
   logic                b_last;
   logic                b_done;
   logic                b_take;
   logic                mean_ready;

   logic [2:0][PB-1:0]  cur_col;
   logic [2:0][PB-1:0]  win1_col;
   logic [2:0][PB-1:0]  win2_col;
   logic [SUM_BITS-1:0] win_sum;
   pos_type             b_pos;
   logic [COL_BITS-1:0] b_x;
   logic [ROW_BITS-1:0] b_y;

   logic [PB-1:0]       rsp_blurred;
   pos_type             rsp_pos;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default:          frame_width_ff  <= frame_width_ff;
         endcase
      end
   end

   // last column and row after zero and limit clamping
   always_comb begin
      w_ext = 15'(frame_width_ff);
      if (w_ext == 15'd0) begin
         col_max = '0;
      end else if (w_ext > 15'(MAX_WIDTH)) begin
         col_max = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         col_max = COL_BITS'(w_ext - 15'd1);
      end
      if (frame_height_ff == '0) begin
         row_max = '0;
      end else if (frame_height_ff > CSR_BITS'(ROW_LIMIT)) begin
         row_max = ROW_BITS'(ROW_LIMIT - 1);
      end else begin
         row_max = ROW_BITS'(frame_height_ff - CSR_BITS'(1));
      end
   end

   // position of the incoming pixel and range of results it releases
   always_comb begin
      col_pre   = req_tuser ? '0 : col_ff;
      row_pre   = req_tuser ? '0 : row_ff;
      acc_c     = (col_pre > col_max) ? col_max : col_pre;
      acc_r     = (row_pre > row_max) ? row_max : row_pre;
      acc_lastc = (acc_c == col_max);
      acc_lastr = (acc_r == row_max);
      if (acc_lastc) begin
         acc_dxs  = (acc_c >= COL_BITS'(2)) ? 2'd2 : 2'(acc_c);
         acc_dxe  = 2'd0;
         acc_hasx = 1'b1;
      end else begin
         acc_dxs  = 2'd2;
         acc_dxe  = 2'd2;
         acc_hasx = (acc_c >= COL_BITS'(2));
      end
      if (acc_lastr) begin
         acc_dys  = (acc_r >= ROW_BITS'(2)) ? 2'd2 : 2'(acc_r);
         acc_dye  = 2'd0;
         acc_hasy = 1'b1;
      end else begin
         acc_dys  = 2'd2;
         acc_dye  = 2'd2;
         acc_hasy = (acc_r >= ROW_BITS'(2));
      end
   end

   // stage handshakes
   assign b_emit     = b_valid_ff && b_has_ff && mean_ready;
   assign b_last     = (b_dx_ff == b_dxe_ff) && (b_dy_ff == b_dye_ff);
   assign b_done     = b_valid_ff && (!b_has_ff || (b_emit && b_last));
   assign b_take     = a_valid_ff && (!b_valid_ff || b_done);
   assign req_tready = !a_valid_ff || b_take;
   assign req_acc    = req_tvalid && req_tready;

   // counters, wrapping at the frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         if (acc_lastc) begin
            col_ff <= '0;
            row_ff <= acc_lastr ? '0 : acc_r + ROW_BITS'(1);
         end else begin
            col_ff <= acc_c + COL_BITS'(1);
            row_ff <= acc_r;
         end
      end
   end

   // line store: rows r-2 and r-1 per column, written as a column leaves
   always_ff @(posedge clock) begin
      if (req_acc) begin
         mem_q_ff <= line_mem[acc_c];
      end
      if (b_done) begin
         line_mem[b_c_ff] <= {b_m1_ff, b_px_ff};
      end
   end

   // read data with bypass of a column written as or after the read was issued
   always_comb begin
      a_eff = (a_fresh_ff && !a_byp_ff) ? mem_q_ff : a_hold_ff;
      a_fwd = (b_done && (b_c_ff == a_c_ff)) ? {b_m1_ff, b_px_ff} : a_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_fresh_ff <= 1'b0;
         a_byp_ff   <= 1'b0;
      end else begin
         if (req_acc) begin
            a_valid_ff <= 1'b1;
         end else if (b_take) begin
            a_valid_ff <= 1'b0;
         end
         a_fresh_ff <= req_acc;
         if (req_acc) begin
            a_byp_ff <= b_done && (b_c_ff == acc_c);
         end
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_hold_ff <= {b_m1_ff, b_px_ff};
         a_px_ff   <= req_tdata[PB-1:0];
         a_c_ff    <= acc_c;
         a_r_ff    <= acc_r;
         a_dxs_ff  <= acc_dxs;
         a_dxe_ff  <= acc_dxe;
         a_dys_ff  <= acc_dys;
         a_dye_ff  <= acc_dye;
         a_has_ff  <= acc_hasx && acc_hasy;
      end else if (a_valid_ff) begin
         a_hold_ff <= a_fwd;
      end
   end

   // window stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_take) begin
         b_valid_ff <= 1'b1;
      end else if (b_done) begin
         b_valid_ff <= 1'b0;
      end
   end

   // window stage payload and result walk, row by row then column by column
   always_ff @(posedge clock) begin
      if (b_take) begin
         b_px_ff  <= a_px_ff;
         b_m1_ff  <= a_fwd[PB-1:0];
         b_m2_ff  <= a_fwd[2*PB-1:PB];
         b_c_ff   <= a_c_ff;
         b_r_ff   <= a_r_ff;
         b_dx_ff  <= a_dxs_ff;
         b_dy_ff  <= a_dys_ff;
         b_dxs_ff <= a_dxs_ff;
         b_dxe_ff <= a_dxe_ff;
         b_dye_ff <= a_dye_ff;
         b_has_ff <= a_has_ff;
      end else if (b_emit) begin
         if (b_dx_ff == b_dxe_ff) begin
            b_dx_ff <= b_dxs_ff;
            b_dy_ff <= b_dy_ff - 2'd1;
         end else begin
            b_dx_ff <= b_dx_ff - 2'd1;
         end
      end
   end

   // window cells: newest column, then one and two columns back
   assign cur_col = {b_px_ff, b_m1_ff, b_m2_ff};

   bblur_cell #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_cell1 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (b_done),
      .col_in   (cur_col),
      .col_out  (win1_col)
   );

   bblur_cell #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_cell2 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (b_done),
      .col_in   (win1_col),
      .col_out  (win2_col)
   );

   // clamped nine-pixel sum for the current result
   always_comb begin
      logic [1:0]    dc;
      logic [1:0]    dr;
      logic [1:0]    k;
      logic [PB-1:0] v;
      win_sum = '0;
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            dc = (b_dx_ff > 2'(i)) ? b_dx_ff - 2'(i) : 2'd0;
            dr = (b_dy_ff > 2'(j)) ? b_dy_ff - 2'(j) : 2'd0;
            k  = 2'd2 - dr;
            case (dc)
               2'd0:    v = cur_col[k];
               2'd1:    v = win1_col[k];
               default: v = win2_col[k];
            endcase
            win_sum = win_sum + SUM_BITS'(v);
         end
      end
   end

   // result position
   always_comb begin
      b_x        = b_c_ff - COL_BITS'(b_dx_ff);
      b_y        = b_r_ff - ROW_BITS'(b_dy_ff);
      b_pos.col  = POS_BITS'(b_x);
      b_pos.row  = POS_BITS'(b_y);
      b_pos.last = b_last;
   end

   bblur_mean #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_mean (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (b_valid_ff && b_has_ff),
      .in_ready    (mean_ready),
      .in_sum      (win_sum),
      .in_pos      (b_pos),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_blurred (rsp_blurred),
      .out_pos     (rsp_pos)
   );

   // result packing
   assign rsp_tdata = RSP_BITS'({rsp_pos.row, rsp_pos.col, rsp_blurred});
   assign rsp_tlast = rsp_pos.last;

   // a result sent on from the window stage lands in the sum register
   a_emit_lands : assert property (@(posedge clock) disable iff (reset)
      b_emit |=> u_mean.sum_valid_ff)
      else $error("window result lost");

   // a finished item without a follower leaves the window stage empty
   a_done_frees : assert property (@(posedge clock) disable iff (reset)
      (b_done && !b_take) |=> !b_valid_ff)
      else $error("window stage not released");

   // fresh read data only exists for a held item
   a_fresh_held : assert property (@(posedge clock) disable iff (reset)
      a_fresh_ff |-> a_valid_ff)
      else $error("read data without item");

   // the walk never starts below its end point
   a_walk_range : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_has_ff) |-> (b_dy_ff >= b_dye_ff && b_dx_ff >= b_dxe_ff))
      else $error("result walk out of range");

endmodule
`default_nettype wire

[bench/box_blur_3x3_clamped_tb.sv]
// self-checking testbench for the 3x3 clamped box blur: directed cases and random frames against a built-in predictor
`default_nettype none
module box_blur_3x3_clamped_tb;
   import bblur_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 600000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [15:0] pixel;
      logic        frame_start;
   } pixel_req_t;

   typedef struct packed {
      logic [15:0]         blurred;
      logic [POS_BITS-1:0] col;
      logic [POS_BITS-1:0] row;
      logic                last;
   } blur_result_t;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [15:0]         req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [39:0]         rsp_tdata;
   logic                rsp_tlast;
   logic                csr_we;
   logic                csr_addr;
   logic [CSR_BITS-1:0] csr_wdata;

   pixel_req_t   pending_q[$];
   blur_result_t blur_expect_q[$];
   int           mismatches;
   int           cycles;
   bit           req_gaps;
   bit           rsp_gaps;
   int           hold_asks;
   int           hold_seen;
   int           hold_left;

   // predictor state
   logic [CSR_BITS-1:0] size_w;
   logic [CSR_BITS-1:0] size_h;
   logic [15:0]         row_m1 [4096];
   logic [15:0]         row_m2 [4096];
   logic [15:0]         win_cells [6];
   int                  col_cnt;
   int                  row_cnt;

   box_blur_3x3_clamped u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pixel
      .req_tuser  (req_tuser),   // frame_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // blurred, out_col, out_row
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_size(logic [CSR_BITS-1:0] v);
      if (v == 0) return 1;
      return (v > 4096) ? 4096 : int'(v);
   endfunction

   // pixel at dc columns and dr rows back from the newest one
   function automatic logic [15:0] cell_at(logic [15:0] cur [3], int dc, int dr);
      int k;
      k = 2 - dr;
      if (dc == 0) return cur[k];
      if (dc == 1) return win_cells[k];
      return win_cells[3 + k];
   endfunction

   // work out the results that one accepted pixel releases
   function automatic void blur_predict(pixel_req_t it);
      int w, h, c, r, xlo, xhi, ylo, yhi, ry, cx;
      logic [15:0] cur [3];
      logic [19:0] sum;
      blur_result_t res;
      w = clamp_size(size_w);
      h = clamp_size(size_h);
      if (it.frame_start) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      c = (col_cnt > w - 1) ? w - 1 : col_cnt;
      r = (row_cnt > h - 1) ? h - 1 : row_cnt;
      cur[0] = row_m2[c];
      cur[1] = row_m1[c];
      cur[2] = it.pixel;
      row_m2[c] = cur[1];
      row_m1[c] = it.pixel;
      if (c == w - 1) begin
         xlo = (c >= 2) ? c - 2 : 0;
         xhi = c;
      end else if (c >= 2) begin
         xlo = c - 2;
         xhi = c - 2;
      end else begin
         xlo = 1;
         xhi = 0;
      end
      if (r == h - 1) begin
         ylo = (r >= 2) ? r - 2 : 0;
         yhi = r;
      end else if (r >= 2) begin
         ylo = r - 2;
         yhi = r - 2;
      end else begin
         ylo = 1;
         yhi = 0;
      end
      for (int y = ylo; y <= yhi; y++) begin
         for (int x = xlo; x <= xhi; x++) begin
            sum = '0;
            for (int j = 0; j < 3; j++) begin
               ry = (y + j > r) ? r : y + j;
               for (int i = 0; i < 3; i++) begin
                  cx = (x + i > c) ? c : x + i;
                  sum += cell_at(cur, c - cx, r - ry);
               end
            end
            res.blurred = 16'((sum + 20'd4) / 20'd9);
            res.col = x[POS_BITS-1:0];
            res.row = y[POS_BITS-1:0];
            res.last = (x == xhi && y == yhi);
            blur_expect_q.push_back(res);
         end
      end
      for (int k = 0; k < 3; k++) begin
         win_cells[3 + k] = win_cells[k];
         win_cells[k] = cur[k];
      end
      if (c == w - 1) begin
         col_cnt = 0;
         row_cnt = (r == h - 1) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
         row_cnt = r;
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   // request driver, predicts each request as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) blur_predict('{req_tdata, req_tuser});
         if (pending_q.size() > 0 && !(req_gaps && $urandom_range(0, 99) < 29)) begin
            pixel_req_t nxt;
            nxt = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.pixel;
            req_tuser  <= nxt.frame_start;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result side: back-pressure and checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_asks != hold_seen || hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rsp_gaps && $urandom_range(0, 99) < 29);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (blur_expect_q.size() == 0) begin
               report_mismatch("unexpected result at col", int'(rsp_tdata[27:16]), -1);
            end else begin
               blur_result_t want;
               want = blur_expect_q.pop_front();
               if (rsp_tdata[15:0] !== want.blurred)
                  report_mismatch("blurred", rsp_tdata[15:0], want.blurred);
               if (rsp_tdata[27:16] !== want.col)
                  report_mismatch("out_col", rsp_tdata[27:16], want.col);
               if (rsp_tdata[39:28] !== want.row)
                  report_mismatch("out_row", rsp_tdata[39:28], want.row);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", rsp_tlast, want.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_size(reg_index_type idx, logic [CSR_BITS-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FRAME_WIDTH) size_w = v;
      else size_h = v;
   endtask

   task automatic set_size(logic [CSR_BITS-1:0] w, logic [CSR_BITS-1:0] h);
      write_size(REG_FRAME_WIDTH, w);
      write_size(REG_FRAME_HEIGHT, h);
   endtask

   // wait until every request is taken and every result checked
   task automatic drain();
      while (pending_q.size() > 0 || req_tvalid || blur_expect_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // n pixels from a frame start, with optional stray restarts
   task automatic queue_pixels(int n, int restart_pct, bit extremes);
      pixel_req_t it;
      for (int i = 0; i < n; i++) begin
         it.pixel = extremes ? (($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000)
                             : 16'($urandom);
         it.frame_start = (i == 0) || ($urandom_range(0, 99) < restart_pct);
         pending_q.push_back(it);
      end
   endtask

   initial begin
      int sent, w, h, n, frames;
      logic [CSR_BITS-1:0] raw_w, raw_h;
      mismatches = 0;
      cycles = 0;
      hold_asks = 0;
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      csr_we = 1'b0;
      csr_addr = REG_FRAME_WIDTH;
      csr_wdata = '0;
      size_w = RESET_FRAME_WIDTH;
      size_h = RESET_FRAME_HEIGHT;
      col_cnt = 0;
      row_cnt = 0;
      foreach (win_cells[k]) win_cells[k] = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset size: first row gives nothing
      queue_pixels(3, 0, 1'b1);
      drain();
      // zero sizes act as one: every pixel is its own result
      set_size(13'd0, 13'd0);
      pending_q.push_back('{16'h0000, 1'b1});
      pending_q.push_back('{16'hffff, 1'b0});
      pending_q.push_back('{16'hffff, 1'b1});
      pending_q.push_back('{16'h5a5a, 1'b0});
      drain();
      // width saturated to the maximum, two rows
      set_size(13'h1fff, 13'd2);
      queue_pixels(4, 0, 1'b1);
      drain();
      // full 3x3 frame, last pixel releases nine results
      set_size(13'd3, 13'd3);
      queue_pixels(9, 0, 1'b1);
      drain();
      // shrink the size part way through a frame
      set_size(13'd6, 13'd6);
      queue_pixels(21, 0, 1'b0);
      drain();
      write_size(REG_FRAME_WIDTH, 13'd2);
      queue_pixels(4, 0, 1'b0);
      pending_q[0].frame_start = 1'b0;
      drain();
      write_size(REG_FRAME_HEIGHT, 13'd2);
      queue_pixels(3, 0, 1'b0);
      pending_q[0].frame_start = 1'b0;
      drain();
      // receiver holds off while two full frames keep coming
      set_size(13'd8, 13'd4);
      hold_asks++;
      queue_pixels(64, 0, 1'b0);
      drain();

      // random frames
      sent = 0;
      frames = 0;
      while (sent < 260) begin
         if ($urandom_range(0, 99) < 80) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
         end else begin
            w = $urandom_range(9, 30);
            h = $urandom_range(1, 3);
         end
         raw_w = (w == 1 && $urandom_range(0, 1) == 1) ? 13'd0 : 13'(w);
         raw_h = (h == 1 && $urandom_range(0, 1) == 1) ? 13'd0 : 13'(h);
         if ($urandom_range(0, 9) == 0) raw_h = 13'($urandom_range(4097, 8191));
         set_size(raw_w, raw_h);
         req_gaps = (frames % 5 != 2);
         rsp_gaps = (frames % 5 != 2);
         if ($urandom_range(0, 99) < 80) begin
            n = w * h * $urandom_range(1, 2);
            queue_pixels(n, 0, 1'b0);
         end else begin
            n = $urandom_range(1, 3 * w * h);
            queue_pixels(n, 8, 1'b0);
         end
         sent += n;
         frames++;
         drain();
      end

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
rtl/core/bblur_pkg.sv
rtl/core/bblur_cell.sv
rtl/core/bblur_mean.sv
rtl/core/box_blur_3x3_clamped.sv
bench/box_blur_3x3_clamped_tb.sv
